FILE: rtl/core/morse_code_keyer_macros.svh
// Assertion macros used by the checker file of the keyer.
`ifndef MORSE_CODE_KEYER_MACROS_SVH
`define MORSE_CODE_KEYER_MACROS_SVH

// Same-cycle implication, sampled on clk, muted while rst is high.
`define MCK_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, muted while rst is high.
`define MCK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/mck_pkg.sv
package mck_pkg;

  // Kind of work handed from the front to the back.
  typedef enum logic [1:0] {
    CMD_SPACE  = 2'd0,
    CMD_LETTER = 2'd1,
    CMD_ERROR  = 2'd2
  } cmd_kind_t;

  // One queued command. For a letter, sym_bits holds the symbols after the
  // leading one, first symbol in the top bit; a set bit is a long mark.
  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] sym_bits;
    logic [2:0] sym_cnt;
  } cmd_t;

  // Handshake between the queue and the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_out_t;

  // Character codes used by the classifier.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_FOLD = 8'h20;

  localparam logic [15:0] UNIT_MS_RESET = 16'd100;

  // Binary-tree index of the letters A to Z.
  function automatic logic [4:0] letter_code(input logic [4:0] idx);
    logic [4:0] code;
    begin
      case (idx)
        5'd0:  code = 5'd5;
        5'd1:  code = 5'd24;
        5'd2:  code = 5'd26;
        5'd3:  code = 5'd12;
        5'd4:  code = 5'd2;
        5'd5:  code = 5'd18;
        5'd6:  code = 5'd14;
        5'd7:  code = 5'd16;
        5'd8:  code = 5'd4;
        5'd9:  code = 5'd23;
        5'd10: code = 5'd13;
        5'd11: code = 5'd20;
        5'd12: code = 5'd7;
        5'd13: code = 5'd6;
        5'd14: code = 5'd15;
        5'd15: code = 5'd22;
        5'd16: code = 5'd29;
        5'd17: code = 5'd10;
        5'd18: code = 5'd8;
        5'd19: code = 5'd3;
        5'd20: code = 5'd9;
        5'd21: code = 5'd17;
        5'd22: code = 5'd11;
        5'd23: code = 5'd25;
        5'd24: code = 5'd27;
        5'd25: code = 5'd28;
        default: code = 5'd0;
      endcase
      return code;
    end
  endfunction

endpackage

FILE: rtl/core/mck_front.sv
module mck_front
  import mck_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] character,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic       after_space;
  logic       aborted;
  logic       after_space_next;
  logic       aborted_next;
  logic       take;
  logic       is_nul;
  logic       is_ws;
  logic       is_lower;
  logic       is_letter;
  logic [7:0] upper;
  logic [4:0] idx;
  logic [4:0] code;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  // Classify the byte and fold lowercase to uppercase.
  always_comb begin
    is_nul    = (character == CH_NUL);
    is_ws     = (character == CH_SPACE) || (character == CH_TAB) ||
                (character == CH_LF) || (character == CH_CR);
    is_lower  = (character >= CH_LOW_A) && (character <= CH_LOW_Z);
    upper     = is_lower ? (character - CASE_FOLD) : character;
    is_letter = (upper >= CH_UP_A) && (upper <= CH_UP_Z);
    idx       = 5'(upper - CH_UP_A);
    code      = letter_code(idx);
  end

  // Build the command; the symbols after the leading one go to the top.
  always_comb begin
    q_cmd = '0;
    if (is_ws) begin
      q_cmd.kind = CMD_SPACE;
    end else if (is_letter) begin
      q_cmd.kind = CMD_LETTER;
      if (code[4]) begin
        q_cmd.sym_cnt  = 3'd4;
        q_cmd.sym_bits = code[3:0];
      end else if (code[3]) begin
        q_cmd.sym_cnt  = 3'd3;
        q_cmd.sym_bits = {code[2:0], 1'b0};
      end else if (code[2]) begin
        q_cmd.sym_cnt  = 3'd2;
        q_cmd.sym_bits = {code[1:0], 2'b00};
      end else begin
        q_cmd.sym_cnt  = 3'd1;
        q_cmd.sym_bits = {code[0], 3'b000};
      end
    end else begin
      q_cmd.kind = CMD_ERROR;
    end
  end

  // A NUL, a muted byte or a repeated whitespace makes no command.
  assign q_push = take && !is_nul && !aborted && !(is_ws && after_space);

  // Message flags.
  always_comb begin
    after_space_next = after_space;
    aborted_next     = aborted;
    if (is_nul) begin
      after_space_next = 1'b0;
      aborted_next     = 1'b0;
    end else if (!aborted) begin
      if (is_ws) begin
        after_space_next = 1'b1;
      end else begin
        after_space_next = 1'b0;
        aborted_next     = !is_letter;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      after_space <= 1'b0;
      aborted     <= 1'b0;
    end else if (take) begin
      after_space <= after_space_next;
      aborted     <= aborted_next;
    end
  end

endmodule

FILE: rtl/core/mck_queue.sv
module mck_queue
  import mck_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  cmd_t   push_cmd,
  output logic   full,
  input  logic   pop,
  output q_out_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];
  assign do_pop     = pop && head.valid;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/mck_back.sv
module mck_back
  import mck_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] unit_ms,
  input  q_out_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        lamp_on,
  output logic [17:0] duration_ms,
  output logic        error,
  output logic        last
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MARK = 4'b0010,
    ST_GAP  = 4'b0100,
    ST_END  = 4'b1000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [3:0]  sym_bits;
  logic [3:0]  sym_bits_next;
  logic [2:0]  sym_cnt;
  logic [2:0]  sym_cnt_next;
  logic        adv;
  logic        emit;
  logic        seg_lamp;
  logic [2:0]  seg_units;
  logic        seg_err;
  logic        seg_last;
  logic [17:0] seg_dur;

  // Unit count times unit length, by shifts and one add.
  function automatic logic [17:0] scale(input logic [15:0] u, input logic [2:0] n);
    logic [17:0] r;
    begin
      case (n)
        3'd1:    r = {2'b00, u};
        3'd2:    r = {1'b0, u, 1'b0};
        3'd3:    r = {2'b00, u} + {1'b0, u, 1'b0};
        3'd4:    r = {u, 2'b00};
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  // The output register can take a segment when empty or being drained.
  assign adv = !out_valid || out_ready;

  // Segment sequencer.
  always_comb begin
    state_next    = state;
    sym_bits_next = sym_bits;
    sym_cnt_next  = sym_cnt;
    pop           = 1'b0;
    emit          = 1'b0;
    seg_lamp      = 1'b0;
    seg_units     = 3'd1;
    seg_err       = 1'b0;
    seg_last      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (adv && head.valid) begin
          pop  = 1'b1;
          emit = 1'b1;
          case (head.cmd.kind)
            CMD_SPACE: begin
              seg_units = 3'd4;
              seg_last  = 1'b1;
            end
            CMD_LETTER: begin
              seg_lamp      = 1'b1;
              seg_units     = head.cmd.sym_bits[3] ? 3'd3 : 3'd1;
              sym_bits_next = {head.cmd.sym_bits[2:0], 1'b0};
              sym_cnt_next  = head.cmd.sym_cnt - 3'd1;
              state_next    = ST_GAP;
            end
            CMD_ERROR: begin
              seg_units = 3'd0;
              seg_err   = 1'b1;
              seg_last  = 1'b1;
            end
            default: begin
              emit = 1'b0;
            end
          endcase
        end
      end
      ST_MARK: begin
        if (adv) begin
          emit          = 1'b1;
          seg_lamp      = 1'b1;
          seg_units     = sym_bits[3] ? 3'd3 : 3'd1;
          sym_bits_next = {sym_bits[2:0], 1'b0};
          sym_cnt_next  = sym_cnt - 3'd1;
          state_next    = ST_GAP;
        end
      end
      ST_GAP: begin
        if (adv) begin
          emit       = 1'b1;
          seg_units  = 3'd1;
          state_next = (sym_cnt == 3'd0) ? ST_END : ST_MARK;
        end
      end
      ST_END: begin
        if (adv) begin
          emit       = 1'b1;
          seg_units  = 3'd2;
          seg_last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign seg_dur = scale(unit_ms, seg_units);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    sym_bits <= sym_bits_next;
    sym_cnt  <= sym_cnt_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      lamp_on     <= seg_lamp;
      duration_ms <= seg_dur;
      error       <= seg_err;
      last        <= seg_last;
    end
  end

endmodule

FILE: rtl/core/morse_code_keyer.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    character
// out       output     out_valid / out_ready  lamp_on, duration_ms, error, last
// cfg       input      cfg_valid / cfg_ready  unit_ms
//
// A letter gives 3 to 9 segments from the back-end sequencer, one per cycle
// unless the output stalls; whitespace or error gives one, a muted byte or NUL none.
// Input bytes are taken every cycle while the command queue has room.
// Reset (rst, synchronous) sets unit_ms to 100, clears the message flags,
// empties the queue and drops out_valid. A stalled output holds its segment
// and the sequencer waits; the front keeps filling the queue meanwhile.
module morse_code_keyer
  import mck_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        lamp_on,
  output logic [17:0] duration_ms,
  output logic        error,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] unit_ms
);

  logic [15:0] unit_reg;
  logic        q_full;
  logic        q_push;
  logic        q_pop;
  cmd_t        q_cmd;
  q_out_t      q_head;

  // Unit length register; a write transfer is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_reg <= UNIT_MS_RESET;
    end else if (cfg_valid) begin
      unit_reg <= unit_ms;
    end
  end

  mck_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  mck_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  mck_back u_back (
    .clk         (clk),
    .rst         (rst),
    .unit_ms     (unit_reg),
    .head        (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .lamp_on     (lamp_on),
    .duration_ms (duration_ms),
    .error       (error),
    .last        (last)
  );

endmodule

FILE: rtl/core/mck_checker.sv
`include "morse_code_keyer_macros.svh"

module mck_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        lamp_on,
  input logic [17:0] duration_ms,
  input logic        error,
  input logic        last
);

  // A stalled segment stays offered.
  `MCK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(duration_ms), "output segment changed while stalled")

  // The error result is a single dark, zero-length, final result.
  `MCK_ASSERT_NOW(a_err_shape, out_valid && error, last && !lamp_on && (duration_ms == 18'd0), "malformed error result")

  // A lit segment is always followed by a dark gap, so it is never final.
  `MCK_ASSERT_NOW(a_lit_not_last, out_valid && lamp_on, !last && !error, "lit segment marked final")

  // After a lit segment is transferred, the next one is dark.
  `MCK_ASSERT_NEXT(a_gap_follows, out_valid && out_ready && lamp_on, !(out_valid && lamp_on), "two lit segments in a row")

endmodule

bind morse_code_keyer mck_checker u_mck_checker (.*);
